// ===== rtl/alarm_clock_with_snooze_unit_assert.svh =====
// Assertion macros for the alarm clock unit checker.
// Expects clk and rst_n in scope where a macro is used.
`ifndef ALARM_CLOCK_WITH_SNOOZE_UNIT_ASSERT_SVH
`define ALARM_CLOCK_WITH_SNOOZE_UNIT_ASSERT_SVH

// Same-cycle implication, reset masked.
`define ACWS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define ACWS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/acws_pkg.sv =====
// Shared types, operation codes and digit tables for the alarm clock unit.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package acws_pkg;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_LOAD_TIME  = 3'd1;
    localparam logic [2:0] OP_LOAD_ALARM = 3'd2;
    localparam logic [2:0] OP_SNOOZE     = 3'd3;
    localparam logic [2:0] OP_DISMISS    = 3'd4;

    localparam logic [4:0] HOUR_LAST    = 5'd23;
    localparam logic [5:0] MINUTE_LAST  = 6'd59;
    localparam logic [5:0] SECOND_LAST  = 6'd59;
    localparam logic [5:0] SNOOZE_STEP  = 6'd10;
    localparam logic [5:0] SNOOZE_SPLIT = 6'd50;

    // Segment bits: A=0 B=1 C=2 D=3 F=4 G=5 E=6
    localparam logic [6:0] DIGIT_SEG [10] = '{
        7'h5F, 7'h06, 7'h6B, 7'h2F, 7'h36, 7'h3D, 7'h7C, 7'h07, 7'h7F, 7'h37
    };

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       show;
    } req_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] disp_hour;
        logic [5:0] disp_minute;
        logic       colon;
        logic       ringing;
        logic       load_error;
    } res_t;

    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] pattern;
        pattern = 7'd0;
        if (digit < 4'd10)
        begin
            pattern = DIGIT_SEG[digit];
        end
        return pattern;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/alarm_clock_with_snooze_unit.sv =====
// Top level of the alarm clock unit: request register, time core, segment decode
// and result register. Depends on acws_pkg, acws_time_core and acws_seg_decode.
`default_nettype none

// 24-hour alarm clock with snooze. Each request (tick, load time, load alarm,
// snooze, dismiss) yields exactly one result carrying the current time, the
// seven-segment patterns of the shown time (current or alarm), the colon, the
// ringing flag and a load error flag. A request is captured in the request
// register, the clock state and the result are computed combinationally by
// the time core and segment decode, and the result lands in the result
// register. One request per cycle is taken sustained while the result side
// does not stall. A stall on the result side holds the result register and
// then the request register; while the result register is empty or draining,
// requests are never stalled. After reset the time is 00:00:00, the alarm
// 01:01, nothing rings, and the first tick shows the colon off.
// Out-of-range loads leave the state untouched and flag load_error.

module alarm_clock_with_snooze_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [4:0] hour_value,
    input  logic [5:0] minute_value,
    input  logic       show_alarm,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] cur_hour,
    output logic [5:0] cur_minute,
    output logic [5:0] cur_second,
    output logic [6:0] seg_hour_tens,
    output logic [6:0] seg_hour_units,
    output logic [6:0] seg_minute_tens,
    output logic [6:0] seg_minute_units,
    output logic       colon_on,
    output logic       ringing,
    output logic       load_error
);
    import acws_pkg::*;

    req_t       req_reg;
    logic       req_valid_reg;
    res_t       res;
    logic [6:0] seg_ht, seg_hu, seg_mt, seg_mu;
    logic       out_free;
    logic       advance;
    logic       in_accept;

    logic       out_valid_reg;
    logic [4:0] cur_hour_reg;
    logic [5:0] cur_minute_reg;
    logic [5:0] cur_second_reg;
    logic [6:0] seg_hour_tens_reg;
    logic [6:0] seg_hour_units_reg;
    logic [6:0] seg_minute_tens_reg;
    logic [6:0] seg_minute_units_reg;
    logic       colon_on_reg;
    logic       ringing_reg;
    logic       load_error_reg;

    // The result register can take a new result when empty or being taken.
    assign out_free  = !out_valid_reg || !out_stall;
    // Move the held request through the core into the result register.
    assign advance   = req_valid_reg && out_free;
    // Stall only while a request waits on a blocked result register.
    assign in_stall  = req_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    // Capture the request payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg.op     <= operation;
            req_reg.hour   <= hour_value;
            req_reg.minute <= minute_value;
            req_reg.show   <= show_alarm;
        end
    end

    acws_time_core u_time_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_reg),
        .res     (res)
    );

    acws_seg_decode u_seg_decode (
        .hour             (res.disp_hour),
        .minute           (res.disp_minute),
        .seg_hour_tens    (seg_ht),
        .seg_hour_units   (seg_hu),
        .seg_minute_tens  (seg_mt),
        .seg_minute_units (seg_mu)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    // Load the result payload only when the previous result is gone.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur_hour_reg         <= res.hour;
            cur_minute_reg       <= res.minute;
            cur_second_reg       <= res.second;
            seg_hour_tens_reg    <= seg_ht;
            seg_hour_units_reg   <= seg_hu;
            seg_minute_tens_reg  <= seg_mt;
            seg_minute_units_reg <= seg_mu;
            colon_on_reg         <= res.colon;
            ringing_reg          <= res.ringing;
            load_error_reg       <= res.load_error;
        end
    end

    assign out_valid        = out_valid_reg;
    assign cur_hour         = cur_hour_reg;
    assign cur_minute       = cur_minute_reg;
    assign cur_second       = cur_second_reg;
    assign seg_hour_tens    = seg_hour_tens_reg;
    assign seg_hour_units   = seg_hour_units_reg;
    assign seg_minute_tens  = seg_minute_tens_reg;
    assign seg_minute_units = seg_minute_units_reg;
    assign colon_on         = colon_on_reg;
    assign ringing          = ringing_reg;
    assign load_error       = load_error_reg;

endmodule

`default_nettype wire

// ===== rtl/acws_time_core.sv =====
// Clock, alarm, ring and colon state with the per-request update logic.
// Depends on acws_pkg.
`default_nettype none

module acws_time_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  acws_pkg::req_t req,
    output acws_pkg::res_t res
);
    import acws_pkg::*;

    logic [4:0] hours_reg, hours_next;
    logic [5:0] minutes_reg, minutes_next;
    logic [5:0] seconds_reg, seconds_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;
    logic       ring_reg, ring_next;
    logic       colon_reg, colon_next;
    logic [4:0] hour_plus_one;
    logic       load_ok;
    logic       load_error;

    assign hour_plus_one = (hours_reg == HOUR_LAST) ? 5'd0 : hours_reg + 5'd1;
    assign load_ok       = (req.hour <= HOUR_LAST) && (req.minute <= MINUTE_LAST);

    always_comb
    begin
        hours_next        = hours_reg;
        minutes_next      = minutes_reg;
        seconds_next      = seconds_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        ring_next         = ring_reg;
        load_error        = 1'b0;
        case (req.op)
            OP_TICK:
            begin
                if (seconds_reg == SECOND_LAST)
                begin
                    seconds_next = 6'd0;
                    if (minutes_reg == MINUTE_LAST)
                    begin
                        minutes_next = 6'd0;
                        hours_next   = hour_plus_one;
                    end
                    else
                    begin
                        minutes_next = minutes_reg + 6'd1;
                    end
                end
                else
                begin
                    seconds_next = seconds_reg + 6'd1;
                end
                if ((hours_next == alarm_hour_reg) && (minutes_next == alarm_minute_reg))
                begin
                    ring_next = 1'b1;
                end
            end
            OP_LOAD_TIME:
            begin
                if (load_ok)
                begin
                    hours_next   = req.hour;
                    minutes_next = req.minute;
                    seconds_next = 6'd0;
                end
                else
                begin
                    load_error = 1'b1;
                end
            end
            OP_LOAD_ALARM:
            begin
                if (load_ok)
                begin
                    alarm_hour_next   = req.hour;
                    alarm_minute_next = req.minute;
                end
                else
                begin
                    load_error = 1'b1;
                end
            end
            OP_SNOOZE:
            begin
                if (ring_reg)
                begin
                    if (minutes_reg < SNOOZE_SPLIT)
                    begin
                        alarm_hour_next   = hours_reg;
                        alarm_minute_next = minutes_reg + SNOOZE_STEP;
                    end
                    else
                    begin
                        alarm_hour_next   = hour_plus_one;
                        alarm_minute_next = minutes_reg - SNOOZE_SPLIT;
                    end
                    ring_next = 1'b0;
                end
            end
            OP_DISMISS:
            begin
                alarm_hour_next   = 5'd0;
                alarm_minute_next = 6'd0;
                ring_next         = 1'b0;
            end
            default:
            begin
                // undefined operation: drop it, state holds
            end
        endcase
    end

    always_comb
    begin
        colon_next = colon_reg;
        if (req.show)
        begin
            res.colon       = 1'b1;
            res.disp_hour   = alarm_hour_next;
            res.disp_minute = alarm_minute_next;
        end
        else
        begin
            res.colon       = colon_reg;
            res.disp_hour   = hours_next;
            res.disp_minute = minutes_next;
            if (req.op == OP_TICK)
            begin
                colon_next = ~colon_reg;
            end
        end
        res.hour       = hours_next;
        res.minute     = minutes_next;
        res.second     = seconds_next;
        res.ringing    = ring_next;
        res.load_error = load_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg        <= 5'd0;
            minutes_reg      <= 6'd0;
            seconds_reg      <= 6'd0;
            alarm_hour_reg   <= 5'd1;
            alarm_minute_reg <= 6'd1;
            ring_reg         <= 1'b0;
            colon_reg        <= 1'b0;
        end
        else if (advance)
        begin
            hours_reg        <= hours_next;
            minutes_reg      <= minutes_next;
            seconds_reg      <= seconds_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            ring_reg         <= ring_next;
            colon_reg        <= colon_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/acws_seg_decode.sv =====
// Splits the shown hour and minute into decimal digits and maps them to segments.
// Depends on acws_pkg for the segment table.
`default_nettype none

module acws_seg_decode (
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    output logic [6:0] seg_hour_tens,
    output logic [6:0] seg_hour_units,
    output logic [6:0] seg_minute_tens,
    output logic [6:0] seg_minute_units
);
    import acws_pkg::*;

    logic [3:0] hour_tens, hour_units;
    logic [3:0] minute_tens, minute_units;
    logic [4:0] hour_rem;
    logic [5:0] minute_rem;

    // Hour is at most 23: two compares give the tens digit.
    always_comb
    begin
        if (hour >= 5'd20)
        begin
            hour_tens = 4'd2;
            hour_rem  = hour - 5'd20;
        end
        else if (hour >= 5'd10)
        begin
            hour_tens = 4'd1;
            hour_rem  = hour - 5'd10;
        end
        else
        begin
            hour_tens = 4'd0;
            hour_rem  = hour;
        end
        hour_units = hour_rem[3:0];
    end

    // Minute is at most 59: compare chain over the tens boundaries.
    always_comb
    begin
        if (minute >= 6'd50)
        begin
            minute_tens = 4'd5;
            minute_rem  = minute - 6'd50;
        end
        else if (minute >= 6'd40)
        begin
            minute_tens = 4'd4;
            minute_rem  = minute - 6'd40;
        end
        else if (minute >= 6'd30)
        begin
            minute_tens = 4'd3;
            minute_rem  = minute - 6'd30;
        end
        else if (minute >= 6'd20)
        begin
            minute_tens = 4'd2;
            minute_rem  = minute - 6'd20;
        end
        else if (minute >= 6'd10)
        begin
            minute_tens = 4'd1;
            minute_rem  = minute - 6'd10;
        end
        else
        begin
            minute_tens = 4'd0;
            minute_rem  = minute;
        end
        minute_units = minute_rem[3:0];
    end

    assign seg_hour_tens    = seg_of(hour_tens);
    assign seg_hour_units   = seg_of(hour_units);
    assign seg_minute_tens  = seg_of(minute_tens);
    assign seg_minute_units = seg_of(minute_units);

endmodule

`default_nettype wire

// ===== rtl/acws_checker.sv =====
// Port-level checker for the alarm clock unit, bound to the top level.
// Depends on acws_pkg and alarm_clock_with_snooze_unit_assert.svh.
`default_nettype none

`include "alarm_clock_with_snooze_unit_assert.svh"

module acws_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] cur_hour,
    input logic [5:0] cur_minute,
    input logic [5:0] cur_second,
    input logic [6:0] seg_hour_tens,
    input logic [6:0] seg_minute_tens
);
    import acws_pkg::*;

    logic time_ok;
    logic hour_tens_ok;
    logic minute_tens_ok;

    assign time_ok = (cur_hour <= HOUR_LAST) && (cur_minute <= MINUTE_LAST)
                  && (cur_second <= SECOND_LAST);
    assign hour_tens_ok = (seg_hour_tens == DIGIT_SEG[0]) || (seg_hour_tens == DIGIT_SEG[1])
                       || (seg_hour_tens == DIGIT_SEG[2]);
    assign minute_tens_ok = (seg_minute_tens == DIGIT_SEG[0])
                         || (seg_minute_tens == DIGIT_SEG[1])
                         || (seg_minute_tens == DIGIT_SEG[2])
                         || (seg_minute_tens == DIGIT_SEG[3])
                         || (seg_minute_tens == DIGIT_SEG[4])
                         || (seg_minute_tens == DIGIT_SEG[5]);

    `ACWS_ASSERT_IMPL(a_time_in_range, out_valid, time_ok, "time out of range")
    `ACWS_ASSERT_IMPL(a_hour_tens_digit, out_valid, hour_tens_ok, "bad hour tens segments")
    `ACWS_ASSERT_IMPL(a_minute_tens_digit, out_valid, minute_tens_ok, "bad minute tens segments")
    `ACWS_ASSERT_IMPL(a_accept_when_drained, in_valid && !out_valid, !in_stall, "request stalled while result empty")
    `ACWS_ASSERT_NEXT(a_stalled_result_held, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind alarm_clock_with_snooze_unit acws_checker u_acws_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cur_hour        (cur_hour),
    .cur_minute      (cur_minute),
    .cur_second      (cur_second),
    .seg_hour_tens   (seg_hour_tens),
    .seg_minute_tens (seg_minute_tens)
);

`default_nettype wire
